### design/stef_pkg.sv
// Shared constants and types for the spanning tree edge filter.
`timescale 1ns / 1ps
`default_nettype none

package stef_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VTX_W        = 10;
    localparam int NV_W         = 11;
    localparam int RANK_W       = 4;
    localparam int CNT_W        = 10;
    localparam int WGT_W        = 16;
    localparam int SUM_W        = 26;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_EDGE  = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0]  parent;
        logic [RANK_W-1:0] rank;
    } t_node;

endpackage

`default_nettype wire

### design/stef_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module stef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/spanning_tree_edge_filter_top.sv
// Kruskal accept stage: union-find forest with union by rank and path compression.
//
// Input channel (i_in_valid / o_in_ready) takes one item: a clear (func 0) or an
// edge (func 1) with two vertex indexes and a signed weight. Output channel
// (o_out_valid / i_out_ready) returns exactly one result per item, in order.
// num_vertices is written through i_cfg_we / i_cfg_wdata only while the block is
// idle: a rule for the user, which the block itself leaves unchecked.
//
// The forest (parent pointer and rank per vertex) sits in one 1024-entry RAM with
// registered read; every walk step is one RAM read. An edge item walks from the
// first end to its root (S_FIND_U), walks that path again pointing each node at
// the root (S_COMP_U), does the same for the second end (S_FIND_V, S_COMP_V), and,
// if the roots differ, links them (S_LINK_A), on a rank tie also bumping the rank
// of the new root (S_LINK_B). Each end is at most 10 deep under union by rank. An
// edge rejected without a walk goes straight to S_DONE; o_in_ready returns with
// the result. Clear item: a sweep rewrites every RAM entry, then gives the result.
// Reset: the same sweep runs with o_in_ready low and no result; num_vertices
// returns to 1024. The result sits in an output register; the next item is taken
// while it waits. If the receiver stalls, a finished item waits in its last state
// until the output register frees up, and no further item is taken.
`timescale 1ns / 1ps
`default_nettype none

module spanning_tree_edge_filter_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [stef_pkg::NV_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_func,
    input  wire logic [stef_pkg::VTX_W-1:0]  i_first_vertex,
    input  wire logic [stef_pkg::VTX_W-1:0]  i_second_vertex,
    input  wire logic signed [stef_pkg::WGT_W-1:0] i_edge_weight,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_accepted,
    output logic [stef_pkg::CNT_W-1:0]       o_tree_edges,
    output logic                             o_forest_complete,
    output logic signed [stef_pkg::SUM_W-1:0] o_total_weight
);

    import stef_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_FIND_U = 4'd2;
    localparam logic [3:0] S_COMP_U = 4'd3;
    localparam logic [3:0] S_FIND_V = 4'd4;
    localparam logic [3:0] S_COMP_V = 4'd5;
    localparam logic [3:0] S_LINK_A = 4'd6;
    localparam logic [3:0] S_LINK_B = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [VTX_W-1:0] LAST_VTX = VTX_W'(MAX_VERTICES - 1);

    logic [3:0]              r_state;
    logic [VTX_W-1:0]        r_cur;
    logic [VTX_W-1:0]        r_u;
    logic [VTX_W-1:0]        r_v;
    logic signed [WGT_W-1:0] r_w;
    logic [VTX_W-1:0]        r_root_u;
    logic [VTX_W-1:0]        r_root_v;
    logic [RANK_W-1:0]       r_rank_u;
    logic [RANK_W-1:0]       r_rank_v;
    logic                    r_acc;
    logic                    r_sweep_item;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [NV_W-1:0]         r_nv;

    logic                    r_o_valid;
    logic                    r_o_accepted;
    logic [CNT_W-1:0]        r_o_tree_edges;
    logic                    r_o_complete;
    logic signed [SUM_W-1:0] r_o_total;

    logic [NV_W-1:0]   vtx_count;
    logic [CNT_W-1:0]  edge_limit;
    logic              in_take;
    logic              out_free;
    logic              ram_we;
    logic [VTX_W-1:0]  ram_waddr;
    t_node             ram_wdata;
    logic [VTX_W-1:0]  ram_raddr;
    t_node             rd;
    logic [RANK_W-1:0] rank_v_inc;

    stef_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (MAX_VERTICES)
    ) u_forest (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // effective vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_nv == '0) begin
            vtx_count = NV_W'(1);
        end else if (r_nv > NV_W'(MAX_VERTICES)) begin
            vtx_count = NV_W'(MAX_VERTICES);
        end else begin
            vtx_count = r_nv;
        end
    end

    assign edge_limit = CNT_W'(vtx_count - NV_W'(1));
    assign in_take    = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;
    assign rank_v_inc = (r_rank_v == RANK_MAX) ? r_rank_v : r_rank_v + RANK_W'(1);

    // RAM port drive; rd always holds the entry addressed in the cycle before
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = '{parent: r_cur, rank: '0};
        ram_raddr = rd.parent;
        case (r_state)
            S_IDLE: begin
                ram_raddr = i_first_vertex;
            end
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_FIND_U, S_FIND_V: begin
                if (rd.parent == r_cur) begin
                    ram_raddr = (r_state == S_FIND_U) ? r_u : r_v;
                end
            end
            S_COMP_U: begin
                if (r_cur == r_root_u) begin
                    ram_raddr = r_v;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = '{parent: r_root_u, rank: rd.rank};
                end
            end
            S_COMP_V: begin
                if (r_cur != r_root_v) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{parent: r_root_v, rank: rd.rank};
                end
            end
            S_LINK_A: begin
                ram_we = 1'b1;
                if (r_rank_u > r_rank_v) begin
                    ram_waddr = r_root_v;
                    ram_wdata = '{parent: r_root_u, rank: r_rank_v};
                end else begin
                    ram_waddr = r_root_u;
                    ram_wdata = '{parent: r_root_v, rank: r_rank_u};
                end
            end
            S_LINK_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_root_v;
                ram_wdata = '{parent: r_root_v, rank: rank_v_inc};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cur        <= '0;
            r_sweep_item <= 1'b0;
            r_acc        <= 1'b0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_nv         <= NV_W'(MAX_VERTICES);
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nv <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_u   <= i_first_vertex;
                        r_v   <= i_second_vertex;
                        r_w   <= i_edge_weight;
                        r_cur <= (i_func == FUNC_CLEAR) ? '0 : i_first_vertex;
                        r_acc <= 1'b0;
                        if (i_func == FUNC_CLEAR) begin
                            r_cnt        <= '0;
                            r_sum        <= '0;
                            r_sweep_item <= 1'b1;
                            r_state      <= S_CLEAR;
                        end else if (r_cnt < edge_limit
                                     && NV_W'(i_first_vertex) < vtx_count
                                     && NV_W'(i_second_vertex) < vtx_count) begin
                            r_state <= S_FIND_U;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLEAR: begin
                    r_cur <= r_cur + VTX_W'(1);
                    if (r_cur == LAST_VTX) begin
                        r_state <= r_sweep_item ? S_DONE : S_IDLE;
                    end
                end
                S_FIND_U: begin
                    if (rd.parent == r_cur) begin
                        r_root_u <= r_cur;
                        r_rank_u <= rd.rank;
                        r_cur    <= r_u;
                        r_state  <= S_COMP_U;
                    end else begin
                        r_cur <= rd.parent;
                    end
                end
                S_COMP_U: begin
                    if (r_cur == r_root_u) begin
                        r_cur   <= r_v;
                        r_state <= S_FIND_V;
                    end else begin
                        r_cur <= rd.parent;
                    end
                end
                S_FIND_V: begin
                    if (rd.parent == r_cur) begin
                        r_root_v <= r_cur;
                        r_rank_v <= rd.rank;
                        r_cur    <= r_v;
                        r_state  <= S_COMP_V;
                    end else begin
                        r_cur <= rd.parent;
                    end
                end
                S_COMP_V: begin
                    if (r_cur == r_root_v) begin
                        r_state <= (r_root_u != r_root_v) ? S_LINK_A : S_DONE;
                    end else begin
                        r_cur <= rd.parent;
                    end
                end
                S_LINK_A: begin
                    r_acc   <= 1'b1;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_sum   <= r_sum + {{(SUM_W - WGT_W){r_w[WGT_W-1]}}, r_w};
                    // equal ranks: the second root also gets its rank bumped
                    r_state <= (r_rank_u == r_rank_v) ? S_LINK_B : S_DONE;
                end
                S_LINK_B: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_accepted   <= r_acc;
                        r_o_tree_edges <= r_cnt;
                        r_o_complete   <= (r_cnt >= edge_limit);
                        r_o_total      <= r_sum;
                        r_sweep_item   <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_accepted        = r_o_accepted;
    assign o_tree_edges      = r_o_tree_edges;
    assign o_forest_complete = r_o_complete;
    assign o_total_weight    = r_o_total;

`ifndef SYNTH
    a_link_distinct_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LINK_A |-> r_root_u != r_root_v)
        else $error("link started on a single root");

    a_accept_has_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_accepted |-> r_o_tree_edges != '0)
        else $error("accepted item reports zero tree edges");

    a_count_moves_on_link_or_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> $past(r_state == S_LINK_A) || $past(r_state == S_IDLE))
        else $error("edge count changed outside link or clear");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_take) |-> !o_in_ready)
        else $error("second item taken before the first was finished");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the spanning tree edge filter (union-find accept stage).
`timescale 1ns / 1ps

module testbench;
    import stef_pkg::*;

    localparam int EDGE_CAP  = (1 << CNT_W) - 1;
    localparam int PLAN_ROWS = 28;

    typedef struct packed {
        logic                    func;
        logic [VTX_W-1:0]        end_a;
        logic [VTX_W-1:0]        end_b;
        logic signed [WGT_W-1:0] weight;
    } t_edge_item;

    typedef struct packed {
        logic                    accepted;
        logic [CNT_W-1:0]        tree_edges;
        logic                    complete;
        logic signed [SUM_W-1:0] total;
    } t_tree_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind       kind;
        logic [NV_W-1:0] nv;
        t_edge_item      item;
        logic            use_table;
        t_tree_result    want;
    } t_plan_row;

    // kind, vertex count, item {func, a, b, weight}, typed?, result {acc, edges, done, sum}
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{ROW_ITEM, 0, '{FUNC_EDGE, 0, 1023, -32768}, 1, '{1, 1, 0, -32768}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 5, 5, 100}, 1, '{0, 1, 0, -32768}},         // self-loop
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1023, 0, 32767}, 1, '{0, 1, 0, -32768}},    // same tree
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1023, 512, 32767}, 1, '{1, 2, 0, -1}},
        '{ROW_CFG, 2, '0, 0, '0},                                  // shrink below count
        '{ROW_ITEM, 0, '{FUNC_EDGE, 0, 1, 0}, 1, '{0, 2, 1, -1}},
        '{ROW_ITEM, 0, '{FUNC_CLEAR, 0, 0, 0}, 1, '{0, 0, 0, 0}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 2, 0, 5}, 1, '{0, 0, 0, 0}},               // end out of range
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1, 0, 7}, 1, '{1, 1, 1, 7}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 0, 1, 8}, 1, '{0, 1, 1, 7}},               // after completion
        '{ROW_CFG, 0, '0, 0, '0},                                  // zero counts as one
        '{ROW_ITEM, 0, '{FUNC_CLEAR, 1023, 1023, -1}, 1, '{0, 0, 1, 0}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 0, 0, 1}, 1, '{0, 0, 1, 0}},
        '{ROW_CFG, 2047, '0, 0, '0},                               // clamps to max
        '{ROW_ITEM, 0, '{FUNC_CLEAR, 0, 0, 0}, 1, '{0, 0, 0, 0}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1023, 1022, -1}, 1, '{1, 1, 0, -1}},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 3, 4, 0}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 5, 6, 0}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 3, 5, 1}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 7, 8, 1}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 9, 10, 1}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 7, 9, 2}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 3, 7, 2}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 4, 10, 3}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1023, 3, 4}, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1022, 10, 5}, 0, '0},
        '{ROW_CFG, 1025, '0, 0, '0},
        '{ROW_ITEM, 0, '{FUNC_EDGE, 1023, 0, 6}, 0, '0}
    };

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_we        = 1'b0;
    logic [NV_W-1:0]                i_cfg_wdata     = '0;
    logic                           i_in_valid      = 1'b0;
    logic                           o_in_ready;
    logic                           i_func          = FUNC_CLEAR;
    logic [VTX_W-1:0]               i_first_vertex  = '0;
    logic [VTX_W-1:0]               i_second_vertex = '0;
    logic signed [WGT_W-1:0]        i_edge_weight   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready     = 1'b0;
    logic                           o_accepted;
    logic [CNT_W-1:0]               o_tree_edges;
    logic                           o_forest_complete;
    logic signed [SUM_W-1:0]        o_total_weight;

    // predictor state
    logic [VTX_W-1:0]  forest_parent [MAX_VERTICES];
    logic [RANK_W-1:0] forest_rank   [MAX_VERTICES];
    int                joined_edges;
    int                weight_total;
    logic [NV_W-1:0]   vertex_setting;

    t_tree_result pending_results [$];

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int hold_off_asks  = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int clears_sent    = 0;
    int config_writes  = 0;
    int edges_joined   = 0;
    int trees_finished = 0;

    spanning_tree_edge_filter_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_first_vertex    (i_first_vertex),
        .i_second_vertex   (i_second_vertex),
        .i_edge_weight     (i_edge_weight),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_accepted        (o_accepted),
        .o_tree_edges      (o_tree_edges),
        .o_forest_complete (o_forest_complete),
        .o_total_weight    (o_total_weight)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_forest();
        for (int i = 0; i < MAX_VERTICES; i++) begin
            forest_parent[i] = VTX_W'(i);
            forest_rank[i]   = '0;
        end
        joined_edges = 0;
        weight_total = 0;
    endfunction

    function automatic int live_vertices();
        if (vertex_setting == 0) return 1;
        if (vertex_setting > MAX_VERTICES) return MAX_VERTICES;
        return int'(vertex_setting);
    endfunction

    function automatic logic [VTX_W-1:0] root_of(input logic [VTX_W-1:0] v);
        logic [VTX_W-1:0] top;
        logic [VTX_W-1:0] cur;
        logic [VTX_W-1:0] nxt;
        top = v;
        while (forest_parent[top] != top) top = forest_parent[top];
        // full compression: every node on the walk now points at the root
        cur = v;
        while (cur != top) begin
            nxt = forest_parent[cur];
            forest_parent[cur] = top;
            cur = nxt;
        end
        return top;
    endfunction

    function automatic t_tree_result kruskal_step(input t_edge_item it);
        int               n;
        int               lim;
        logic [VTX_W-1:0] ra;
        logic [VTX_W-1:0] rb;
        t_tree_result     res;
        n   = live_vertices();
        lim = (n - 1 > EDGE_CAP) ? EDGE_CAP : n - 1;
        res.accepted = 1'b0;
        if (it.func == FUNC_CLEAR) begin
            reset_forest();
        end else if (joined_edges < lim && it.end_a < n && it.end_b < n) begin
            ra = root_of(it.end_a);
            rb = root_of(it.end_b);
            if (ra != rb) begin
                // tie: first root goes under the second, whose rank grows
                if (forest_rank[ra] == forest_rank[rb]) begin
                    forest_parent[ra] = rb;
                    if (forest_rank[rb] != RANK_MAX) forest_rank[rb] = forest_rank[rb] + 1'b1;
                end else if (forest_rank[ra] > forest_rank[rb]) begin
                    forest_parent[rb] = ra;
                end else begin
                    forest_parent[ra] = rb;
                end
                joined_edges++;
                weight_total += it.weight;
                res.accepted = 1'b1;
            end
        end
        res.tree_edges = joined_edges[CNT_W-1:0];
        res.complete   = (joined_edges >= lim);
        res.total      = weight_total[SUM_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input longint got, input longint want);
        $display("%0t ns: result %0d, %s is %0d, expected %0d",
                 $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // config is written only with the block drained
    task automatic write_vertex_count(input logic [NV_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        vertex_setting = value;
        config_writes++;
    endtask

    task automatic send_item(input t_edge_item it, input logic use_table,
                             input t_tree_result table_want);
        int           gap;
        t_tree_result want;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= it.func;
        i_first_vertex  <= it.end_a;
        i_second_vertex <= it.end_b;
        i_edge_weight   <= it.weight;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        want = kruskal_step(it);
        if (use_table) want = table_want;
        pending_results = {pending_results, want};
        items_sent++;
        if (it.func == FUNC_CLEAR) clears_sent++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_tree_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unrequested item", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.accepted)
                    flag_mismatch("accepted", o_accepted, want.accepted);
                if (o_tree_edges !== want.tree_edges)
                    flag_mismatch("tree_edges", o_tree_edges, want.tree_edges);
                if (o_forest_complete !== want.complete)
                    flag_mismatch("forest_complete", o_forest_complete, want.complete);
                if (o_total_weight !== want.total)
                    flag_mismatch("total_weight", o_total_weight, want.total);
                if (want.accepted) edges_joined++;
                if (want.accepted && want.complete) trees_finished++;
            end
            results_seen++;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (served != hold_off_asks) begin
                served    = hold_off_asks;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_edge_item it;
        int         nv;
        int         n;
        int         count;
        int         sel;
        int         pick;
        int         wcur;
        int         target;
        logic       pressure_due;
        vertex_setting = NV_W'(MAX_VERTICES);
        reset_forest();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset runs a clearing sweep before the first item is taken
        do @(posedge i_clk); while (o_in_ready !== 1'b1);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].kind == ROW_CFG) write_vertex_count(PLAN[r].nv);
            else send_item(PLAN[r].item, PLAN[r].use_table, PLAN[r].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 34 : 0;
            rx_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 34 : 0;
            pressure_due = (phase == 0 || phase == 2);
            target       = items_sent + 282;
            while (items_sent < target) begin
                sel = $urandom_range(99);
                if (sel < 65)      nv = $urandom_range(2, 40);
                else if (sel < 78) nv = $urandom_range(41, 300);
                else if (sel < 90) nv = $urandom_range(900, 1024);
                else if (sel < 95) nv = $urandom_range(0, 1);
                else               nv = $urandom_range(1025, 2047);
                write_vertex_count(nv[NV_W-1:0]);
                n = live_vertices();
                // now and then keep the old forest, possibly already past the new limit
                if ($urandom_range(9) != 0) begin
                    it.func   = FUNC_CLEAR;
                    it.end_a  = VTX_W'($urandom_range(0, 1023));
                    it.end_b  = VTX_W'($urandom_range(0, 1023));
                    it.weight = WGT_W'($urandom_range(0, 65535));
                    send_item(it, 1'b0, '0);
                end
                count = (n <= 40) ? $urandom_range(n, 3 * n) : $urandom_range(20, 60);
                wcur  = $urandom_range(0, 32768) - 32768;
                for (int k = 0; k < count && items_sent < target; k++) begin
                    if (pressure_due && k == 4) begin
                        hold_off_asks++;
                        pressure_due = 1'b0;
                    end
                    pick      = $urandom_range(99);
                    it.func   = FUNC_EDGE;
                    it.end_a  = VTX_W'($urandom_range(0, n - 1));
                    it.end_b  = VTX_W'($urandom_range(0, n - 1));
                    it.weight = WGT_W'(wcur);
                    if (pick < 5) begin
                        it.end_a = VTX_W'($urandom_range(0, 1023));
                        it.end_b = VTX_W'($urandom_range(0, 1023));
                    end else if (pick < 9) begin
                        it.end_b = it.end_a;
                    end else if (pick < 12) begin
                        it.weight = WGT_W'($urandom_range(0, 65535));
                    end else if (pick < 14) begin
                        it.func = FUNC_CLEAR;
                    end
                    send_item(it, 1'b0, '0);
                    // well-formed runs keep weights nondecreasing
                    wcur += $urandom_range(0, 65535 / (count + 1));
                    if (wcur > 32767) wcur = 32767;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("ran %0d items: %0d clears, %0d edges joined, %0d trees completed",
                 items_sent, clears_sent, edges_joined, trees_finished);
        $display("%0d vertex-count writes, four idle mixes, %0d long output hold-offs",
                 config_writes, hold_off_asks);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("timeout with %0d items still outstanding", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/stef_pkg.sv
design/stef_ram.sv
design/spanning_tree_edge_filter_top.sv
tb/testbench.sv
